FILE: rtl/core/ncdf_pkg.sv
// ncdf_pkg: shared types, signed Q4.30 coefficient tables and the rounded
// product used by the normal cdf Horner stages. No dependencies.
package ncdf_pkg;

  localparam int Q              = 30;
  localparam int ACC_W          = 34;
  localparam int N_STAGES       = 14;
  localparam int IN_W           = 16;
  localparam int OUT_W          = 17;
  localparam int DEF_IN_FRAC    = 11;
  localparam int DEF_OUT_FRAC   = 16;

  typedef logic signed [ACC_W-1:0] acc_t;

  localparam acc_t ONE_Q = acc_t'(1) <<< Q;

  localparam acc_t INNER_C [9] = '{
    acc_t'(134023), acc_t'(-1154492), acc_t'(5582142), acc_t'(-20614009),
    acc_t'(63408788), acc_t'(-163175204), acc_t'(342687852),
    acc_t'(-571147980), acc_t'(856722023)
  };

  localparam acc_t OUTER_C [15] = '{
    acc_t'(-48593), acc_t'(163777), acc_t'(-20979), acc_t'(-726821),
    acc_t'(1493150), acc_t'(-853218), acc_t'(-2184265), acc_t'(7032785),
    acc_t'(-11336164), acc_t'(12488098), acc_t'(-9963737), acc_t'(5748362),
    acc_t'(-2299170), acc_t'(574785), acc_t'(1073673811)
  };

  typedef struct packed {
    logic inner;
    logic zero;
    logic tail;
    logic neg;
    acc_t acc;
    acc_t opnd;
    acc_t y;
  } stage_t;

  // q30 product, round to nearest, halves away from zero
  function automatic acc_t qmul(acc_t a, acc_t b);
    logic                 neg;
    logic [ACC_W-1:0]     ma;
    logic [ACC_W-1:0]     mb;
    logic [2*ACC_W-1:0]   p;
    logic [ACC_W-1:0]     m;
    neg = a[ACC_W-1] ^ b[ACC_W-1];
    ma  = a[ACC_W-1] ? ACC_W'(-a) : ACC_W'(a);
    mb  = b[ACC_W-1] ? ACC_W'(-b) : ACC_W'(b);
    p   = {{ACC_W{1'b0}}, ma} * {{ACC_W{1'b0}}, mb}
        + ((2*ACC_W)'(1) << (Q-1));
    m   = p[Q +: ACC_W];
    return neg ? acc_t'(-m) : acc_t'(m);
  endfunction

endpackage

FILE: rtl/core/ncdf_front.sv
// ncdf_front: argument decode, range flags and Q4.30 operand set-up.
// Depends on ncdf_pkg.
module ncdf_front import ncdf_pkg::*; #(
  parameter int IN_FRAC_BITS = DEF_IN_FRAC
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_v,
  input  logic signed [IN_W-1:0] arg,
  output logic                   v_r,
  output stage_t                 st_r
);

  logic [IN_W:0] ax;
  logic          neg;
  acc_t          y;
  stage_t        st_nxt;

  always_comb begin
    neg = arg[IN_W-1];
    ax  = neg ? (IN_W+1)'(-{arg[IN_W-1], arg}) : (IN_W+1)'({1'b0, arg});
    y   = acc_t'(ax) <<< (Q - 1 - IN_FRAC_BITS);
    st_nxt.neg   = neg;
    st_nxt.zero  = (arg == '0);
    st_nxt.tail  = {15'd0, ax} >= (32'd6 << IN_FRAC_BITS);
    st_nxt.inner = {15'd0, ax} <  (32'd2 << IN_FRAC_BITS);
    st_nxt.y     = y;
    st_nxt.opnd  = y - (ONE_Q <<< 1);
    st_nxt.acc   = OUTER_C[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
    end
  end

endmodule

FILE: rtl/core/ncdf_horner_stage.sv
// ncdf_horner_stage: one Horner step, a rounded multiply and add, per stage;
// inner stages 1, 10 only multiply; 11-14 pass on. Depends on ncdf_pkg.
module ncdf_horner_stage import ncdf_pkg::*; #(
  parameter int STAGE = 1
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   en,
  input  logic   in_v,
  input  stage_t st_in,
  output logic   v_r,
  output stage_t st_r
);

  localparam int II = (STAGE >= 2 && STAGE <= 9) ? STAGE - 1 : 0;
  localparam int OI = (STAGE >= 1 && STAGE <= 14) ? STAGE : 0;

  acc_t   a;
  acc_t   b;
  acc_t   p;
  stage_t st_nxt;

  always_comb begin
    st_nxt = st_in;
    a = (st_in.inner && STAGE == 1) ? st_in.y : st_in.acc;
    if (!st_in.inner) begin
      b = st_in.opnd;
    end else if (STAGE == 1) begin
      b = st_in.y;
    end else if (STAGE == 10) begin
      b = st_in.y <<< 1;
    end else begin
      b = st_in.opnd;
    end
    p = qmul(a, b);
    if (st_in.inner) begin
      if (STAGE == 1) begin
        st_nxt.opnd = p;
        st_nxt.acc  = INNER_C[0];
      end else if (STAGE <= 9) begin
        st_nxt.acc = p + INNER_C[II];
      end else if (STAGE == 10) begin
        st_nxt.acc = p;
      end
    end else begin
      st_nxt.acc = p + OUTER_C[OI];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
    end
  end

endmodule

FILE: rtl/core/ncdf_back.sv
// ncdf_back: sign mirror, clamp, output rounding and output register.
// Depends on ncdf_pkg.
module ncdf_back import ncdf_pkg::*; #(
  parameter int OUT_FRAC_BITS = DEF_OUT_FRAC
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_v,
  input  stage_t           st_in,
  input  logic             out_stall,
  output logic             rdy,
  output logic             out_valid,
  output logic [OUT_W-1:0] out_probability
);

  localparam int SHIFT = 31 - OUT_FRAC_BITS;

  logic signed [ACC_W:0] s;
  logic [ACC_W:0]        r;
  acc_t                  z;
  logic [OUT_W-1:0]      prob_nxt;

  assign rdy = !out_valid || !out_stall;

  always_comb begin
    z = st_in.tail ? ONE_Q : st_in.acc;
    s = st_in.neg ? ((ACC_W+1)'(ONE_Q) - (ACC_W+1)'(z))
                  : ((ACC_W+1)'(ONE_Q) + (ACC_W+1)'(z));
    if (s < 0) begin
      s = '0;
    end else if (s > ((ACC_W+1)'(ONE_Q) <<< 1)) begin
      s = (ACC_W+1)'(ONE_Q) <<< 1;
    end
    r = ((ACC_W+1)'(s) + ((ACC_W+1)'(1) << (SHIFT-1))) >> SHIFT;
    prob_nxt = st_in.zero ? OUT_W'(1) << (OUT_FRAC_BITS-1) : r[OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (rdy) begin
      out_valid <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy) begin
      out_probability <= prob_nxt;
    end
  end

endmodule

FILE: rtl/core/normal_cdf_polynomial.sv
// normal_cdf_polynomial: standard normal lower-tail probability of a signed
// fixed-point argument. One word is taken per cycle unless in_stall is high;
// each word passes the decode register, the 14 Horner multiply stages and
// the output register. Stalls hold each stage only while it is full.
module normal_cdf_polynomial import ncdf_pkg::*; #(
  parameter int IN_FRAC_BITS  = DEF_IN_FRAC,
  parameter int OUT_FRAC_BITS = DEF_OUT_FRAC
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic signed [IN_W-1:0] in_argument,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [OUT_W-1:0]       out_probability
);

  stage_t st [N_STAGES+1];
  logic   v  [N_STAGES+1];
  logic   rdy [N_STAGES+2];
  logic   rdy_back;

  always_comb begin
    rdy[N_STAGES+1] = rdy_back;
    for (int i = N_STAGES; i >= 0; i--) begin
      rdy[i] = !v[i] || rdy[i+1];
    end
  end

  assign in_stall = !rdy[0];

  ncdf_front #(.IN_FRAC_BITS(IN_FRAC_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .en(rdy[0]), .in_v(in_valid),
    .arg(in_argument), .v_r(v[0]), .st_r(st[0])
  );

  for (genvar g = 1; g <= N_STAGES; g++) begin : g_stage
    ncdf_horner_stage #(.STAGE(g)) u_stage (
      .clk(clk), .rst_n(rst_n), .en(rdy[g]), .in_v(v[g-1]),
      .st_in(st[g-1]), .v_r(v[g]), .st_r(st[g])
    );
  end

  ncdf_back #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .in_v(v[N_STAGES]), .st_in(st[N_STAGES]),
    .out_stall(out_stall), .rdy(rdy_back),
    .out_valid(out_valid), .out_probability(out_probability)
  );

endmodule

FILE: rtl/core/ncdf_checker.sv
// ncdf_checker: port-level checks on the normal cdf pipeline, bound to the
// top level. Depends on ncdf_pkg.
module ncdf_checker import ncdf_pkg::*; #(
  parameter int OUT_FRAC_BITS = DEF_OUT_FRAC
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [OUT_W-1:0] out_probability
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_probability))
    else $error("stalled word changed");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_probability <= (OUT_W'(1) << OUT_FRAC_BITS))
    else $error("probability above one");

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with free output");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("word out of reset");

endmodule

bind normal_cdf_polynomial ncdf_checker #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_ncdf_checker (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_probability(out_probability)
);

FILE: tb/tb_normal_cdf_polynomial.sv
// tb_normal_cdf_polynomial: random and directed test of the normal cdf pipeline
// against a bit-exact probability predictor held in a small scoreboard class.
// Depends on ncdf_pkg and normal_cdf_polynomial.
module tb_normal_cdf_polynomial;
  import ncdf_pkg::*;

  localparam int FRAC_IN  = DEF_IN_FRAC;
  localparam int FRAC_OUT = DEF_OUT_FRAC;
  localparam int N_RANDOM = 1400;
  localparam int STALL_LIMIT = 2000;

  typedef logic signed [63:0] q_t;

  class cdf_scoreboard;
    logic [OUT_W-1:0] expected_probs[$];
    int errors;

    function q_t round_mul(q_t a, q_t b);
      logic neg;
      logic [63:0] ma;
      logic [63:0] mb;
      logic [127:0] p;
      neg = (a < 0) != (b < 0);
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      p = ma * mb + (128'd1 << (Q - 1));
      p = p >> Q;
      return neg ? -q_t'(p[63:0]) : q_t'(p[63:0]);
    endfunction

    function logic [OUT_W-1:0] lower_tail(logic signed [IN_W-1:0] arg);
      q_t x;
      q_t ax;
      q_t y;
      q_t z;
      q_t s;
      q_t acc;
      logic [63:0] r;
      int sh;
      x = arg;
      ax = (x < 0) ? -x : x;
      sh = 31 - FRAC_OUT;
      if (x == 0) return OUT_W'(1) << (FRAC_OUT - 1);
      if (ax >= (q_t'(6) <<< FRAC_IN)) begin
        z = q_t'(1) <<< Q;
      end else begin
        y = ax <<< (Q - 1 - FRAC_IN);
        if (ax < (q_t'(2) <<< FRAC_IN)) begin
          acc = INNER_C[0];
          for (int i = 1; i < 9; i++) acc = round_mul(acc, round_mul(y, y)) + q_t'(INNER_C[i]);
          z = round_mul(acc, 2 * y);
        end else begin
          acc = OUTER_C[0];
          for (int i = 1; i < 15; i++)
            acc = round_mul(acc, y - (q_t'(2) <<< Q)) + q_t'(OUTER_C[i]);
          z = acc;
        end
      end
      s = (x < 0) ? (q_t'(1) <<< Q) - z : (q_t'(1) <<< Q) + z;
      if (s < 0) s = 0;
      if (s > (q_t'(2) <<< Q)) s = q_t'(2) <<< Q;
      r = (s + (q_t'(1) <<< (sh - 1))) >>> sh;
      return r[OUT_W-1:0];
    endfunction

    function void note_argument(logic signed [IN_W-1:0] arg);
      expected_probs.push_back(lower_tail(arg));
    endfunction

    task report_mismatch(string what, logic [OUT_W-1:0] got, logic [OUT_W-1:0] want);
      $display("mismatch %s: got %0d want %0d", what, got, want);
      errors++;
    endtask

    task check_probability(logic [OUT_W-1:0] got);
      logic [OUT_W-1:0] want;
      if (expected_probs.size() == 0) begin
        report_mismatch("probability with none expected", got, '0);
        return;
      end
      want = expected_probs.pop_front();
      if (got !== want) report_mismatch("probability", got, want);
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [IN_W-1:0] in_argument;
  logic out_valid;
  logic out_stall;
  logic [OUT_W-1:0] out_probability;

  cdf_scoreboard sb;
  logic busy_phase;
  int quiet_cycles = 0;

  normal_cdf_polynomial dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_argument(in_argument),
    .out_valid(out_valid), .out_stall(out_stall), .out_probability(out_probability)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic idle_now();
    return !busy_phase && ($urandom_range(99) < 38);
  endfunction

  task automatic send_word(logic signed [IN_W-1:0] arg);
    while (idle_now()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_argument <= arg;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_argument(arg);
    @(negedge clk);
  endtask

  function automatic logic signed [IN_W-1:0] random_argument();
    case ($urandom_range(5))
      0: return IN_W'($urandom);
      1: return $signed(IN_W'($urandom_range(0, 4095))) - 16'sd2048;
      2: return $signed(IN_W'($urandom_range(4096, 12287)));
      3: return -$signed(IN_W'($urandom_range(4096, 12287)));
      4: return IN_W'($signed(IN_W'($urandom_range(12280, 12300))) *
                      ($urandom_range(1) ? 1 : -1));
      default: return $signed(IN_W'($urandom_range(0, 8))) - 16'sd4;
    endcase
  endfunction

  always @(negedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= idle_now();
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_probability(out_probability);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    logic signed [IN_W-1:0] directed[$];
    sb = new();
    busy_phase = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_argument = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    directed = '{16'sd0, 16'sd1, -16'sd1, 16'sh7fff, -16'sh8000, 16'sd4095, 16'sd4096,
                 -16'sd4095, -16'sd4096, 16'sd12287, 16'sd12288, -16'sd12287,
                 -16'sd12288, 16'sd2048, -16'sd2048, 16'sd8192, -16'sd8192,
                 16'sh5555, -16'sh5556, 16'sd6000, -16'sd10000};
    foreach (directed[i]) send_word(directed[i]);
    for (int i = 0; i < N_RANDOM; i++) begin
      busy_phase = (i >= 500 && i < 700);
      send_word(random_argument());
    end
    in_valid <= 1'b0;
    busy_phase = 1'b0;
    while (sb.expected_probs.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
